// ----- hw/rtl/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and twiddle table functions of the radix-2 FFT.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int MAX_LOG2_SIZE_DEF = 10;
  localparam int INPUT_WIDTH_DEF   = 24;
  localparam int WORD_WIDTH_DEF    = 36;
  localparam int BIN_INDEX_W       = 10;
  localparam int LOG2_W            = 4;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 4;
  localparam int SIZE_LOG2_RESET   = 10;
  localparam int TW_W              = 19;
  localparam int TW_FRAC           = 17;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } command_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_LOG2    = 2'd0,
    REG_INVERSE_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    DP_NOP    = 4'd0,
    DP_LOAD   = 4'd1,
    DP_READ   = 4'd2,
    DP_FETCH  = 4'd3,
    DP_MUL0   = 4'd4,
    DP_MUL1   = 4'd5,
    DP_MUL2   = 4'd6,
    DP_MUL3   = 4'd7,
    DP_ACC    = 4'd8,
    DP_WR_SUM = 4'd9,
    DP_WR_DIF = 4'd10,
    DP_SWAP_A = 4'd11,
    DP_SWAP_B = 4'd12,
    DP_SCALE  = 4'd13
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              inverse;
    logic [LOG2_W-1:0] lg;
    logic              done;
  } dp_cmd_t;

  // Taylor term denominators (2i)(2i+1) for sine and (2i-1)(2i) for cosine.
  function automatic logic [63:0] div_sin_den(input int i, input logic [63:0] v);
    logic [63:0] q;
    case (i)
      1:       q = v / 64'd6;
      2:       q = v / 64'd20;
      3:       q = v / 64'd42;
      4:       q = v / 64'd72;
      5:       q = v / 64'd110;
      6:       q = v / 64'd156;
      7:       q = v / 64'd210;
      8:       q = v / 64'd272;
      9:       q = v / 64'd342;
      default: q = v / 64'd420;
    endcase
    return q;
  endfunction

  function automatic logic [63:0] div_cos_den(input int i, input logic [63:0] v);
    logic [63:0] q;
    case (i)
      1:       q = v / 64'd2;
      2:       q = v / 64'd12;
      3:       q = v / 64'd30;
      4:       q = v / 64'd56;
      5:       q = v / 64'd90;
      6:       q = v / 64'd132;
      7:       q = v / 64'd182;
      8:       q = v / 64'd240;
      9:       q = v / 64'd306;
      default: q = v / 64'd380;
    endcase
    return q;
  endfunction

  function automatic logic signed [TW_W-1:0] q30_to_q17(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic [63:0] q;
    t = (v < 0) ? 64'sd0 : v;
    q = ($unsigned(t) + 64'd4096) >> 13;
    if (q > 64'd131072) begin
      q = 64'd131072;
    end
    return $signed(q[TW_W-1:0]);
  endfunction

  // Cosine and sine in Q17 of the angle 2*pi*m/2^max_log2, up to a quarter turn.
  function automatic logic [2*TW_W-1:0] tw_quarter(input logic [63:0] m, input int max_log2);
    logic [63:0] x;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    x  = (PI_Q30 * 64'd2 * m + (64'd1 << (max_log2 - 1))) >> max_log2;
    ts = x;
    tc = 64'd1 << 30;
    ss = $signed(x);
    cs = $signed(tc);
    for (int i = 1; i <= 10; i++) begin
      ts = div_sin_den(i, ((((ts * x) >> 30) * x) >> 30));
      tc = div_cos_den(i, ((((tc * x) >> 30) * x) >> 30));
      if ((i & 1) != 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    return {q30_to_q17(cs), q30_to_q17(ss)};
  endfunction

  function automatic logic [2*TW_W-1:0] tw_entry(input int k, input int max_log2);
    logic [2*TW_W-1:0] cs;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    int quarter;
    quarter = (1 << max_log2) >> 2;
    if (k <= quarter) begin
      cs = tw_quarter(64'(k), max_log2);
    end else begin
      cs = tw_quarter(64'(k - quarter), max_log2);
      c  = $signed(cs[2*TW_W-1:TW_W]);
      s  = $signed(cs[TW_W-1:0]);
      cs = {-s, c};
    end
    return cs;
  endfunction

endpackage

// ----- hw/rtl/r2fft_ram.sv -----
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module r2fft_ram
  import r2fft_pkg::*;
#(
  parameter int WIDTH = 2 * WORD_WIDTH_DEF,
  parameter int DEPTH = 1 << MAX_LOG2_SIZE_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hw/rtl/r2fft_twiddle.sv -----
// ----------------------------------------------------------------------------
// r2fft_twiddle
// Twiddle ROM over half a turn, cosine and sine in Q1.17, registered read.
// ----------------------------------------------------------------------------
module r2fft_twiddle
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  localparam int TW_AW = (MAX_LOG2_SIZE > 1) ? MAX_LOG2_SIZE - 1 : 1
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [TW_AW-1:0]       addr,
  output logic signed [TW_W-1:0] cos_q,
  output logic signed [TW_W-1:0] sin_q
);

  localparam int TW_DEPTH = 1 << TW_AW;

  logic [2*TW_W-1:0] rom [TW_DEPTH];

  for (genvar g = 0; g < TW_DEPTH; g++) begin : g_rom
    assign rom[g] = tw_entry(g, MAX_LOG2_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_q <= $signed(rom[addr][2*TW_W-1:TW_W]);
      sin_q <= $signed(rom[addr][TW_W-1:0]);
    end
  end

endmodule

// ----- hw/rtl/r2fft_ctrl.sv -----
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Command decode, configuration registers and the transform sequencer.
// ----------------------------------------------------------------------------
module r2fft_ctrl
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  localparam int AW = MAX_LOG2_SIZE,
  localparam int TW_AW = (MAX_LOG2_SIZE > 1) ? MAX_LOG2_SIZE - 1 : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   command,
  input  logic [BIN_INDEX_W-1:0] bin_index,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   busy,
  output logic                   cfg_ready,
  output dp_cmd_t                cmd,
  output logic [AW-1:0]          addr_a,
  output logic [AW-1:0]          addr_b,
  output logic [TW_AW-1:0]       tw_addr
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'd1,
    S_BR_CHK = 14'd2,
    S_BR_WA  = 14'd4,
    S_BR_WB  = 14'd8,
    S_BF_RD  = 14'd16,
    S_BF_M0  = 14'd32,
    S_BF_M1  = 14'd64,
    S_BF_M2  = 14'd128,
    S_BF_M3  = 14'd256,
    S_BF_ADD = 14'd512,
    S_BF_WA  = 14'd1024,
    S_BF_WB  = 14'd2048,
    S_SC_RD  = 14'd4096,
    S_SC_WR  = 14'd8192
  } state_t;

  localparam logic [LOG2_W-1:0] LG_RESET =
    LOG2_W'((SIZE_LOG2_RESET > MAX_LOG2_SIZE) ? MAX_LOG2_SIZE : SIZE_LOG2_RESET);

  state_t            state, state_next;
  logic [LOG2_W-1:0] lg, lg_next;
  logic              inverse, inverse_next;
  logic [AW:0]       load_count, load_count_next;
  logic              transform_done, transform_done_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic [LOG2_W-1:0] stage, stage_next;
  dp_op_t            op;

  logic [AW:0]       n_full;
  logic [AW:0]       n_m1;
  logic [AW-1:0]     n_mask;
  logic [AW-1:0]     last_t;
  logic [AW:0]       lc_plus;
  logic [AW-1:0]     rev_full;
  logic [AW-1:0]     rev;
  logic [AW-1:0]     half_bit;
  logic [AW-1:0]     half_mask;
  logic [AW-1:0]     bf_a;
  logic [AW-1:0]     bf_b;
  logic [AW-1:0]     tw_full;
  logic [AW+BIN_INDEX_W-1:0] bin_ext;
  logic [AW-1:0]     rd_idx;

  assign n_full  = (AW+1)'(1) << lg;
  assign n_m1    = n_full - (AW+1)'(1);
  assign n_mask  = n_m1[AW-1:0];
  assign last_t  = n_mask >> 1;
  assign lc_plus = load_count + (AW+1)'(1);

  // Bit reversal over the full address, then aligned to the length in use.
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt[AW-1-b];
    end
  end
  assign rev = rev_full >> (LOG2_W'(MAX_LOG2_SIZE) - lg);

  // Butterfly t of a stage: insert a zero at the half-span bit to get the top leg.
  assign half_bit  = AW'(1) << (stage - LOG2_W'(1));
  assign half_mask = half_bit - AW'(1);
  assign bf_a      = ((cnt & ~half_mask) << 1) | (cnt & half_mask);
  assign bf_b      = bf_a | half_bit;
  assign tw_full   = (cnt & half_mask) << (LOG2_W'(MAX_LOG2_SIZE) - stage);
  assign tw_addr   = tw_full[TW_AW-1:0];

  assign bin_ext = {{AW{1'b0}}, bin_index};
  assign rd_idx  = bin_ext[AW-1:0] & n_mask;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    unique case (state) inside
      S_IDLE: begin
        addr_a = (command == CMD_READ) ? rd_idx : load_count[AW-1:0];
        addr_b = addr_a;
      end
      S_BR_CHK, S_BR_WA, S_BR_WB: begin
        addr_a = cnt;
        addr_b = rev;
      end
      S_SC_RD, S_SC_WR: begin
        addr_a = cnt;
        addr_b = cnt;
      end
      default: begin
        addr_a = bf_a;
        addr_b = bf_b;
      end
    endcase
  end

  always_comb begin
    state_next          = state;
    lg_next             = lg;
    inverse_next        = inverse;
    load_count_next     = load_count;
    transform_done_next = transform_done;
    cnt_next            = cnt;
    stage_next          = stage;
    op                  = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_READ) begin
            op = DP_READ;
          end else begin
            op = DP_LOAD;
            transform_done_next = 1'b0;
            if (lc_plus == n_full) begin
              load_count_next = '0;
              cnt_next        = '0;
              state_next      = S_BR_CHK;
            end else begin
              load_count_next = lc_plus;
            end
          end
        end
      end
      S_BR_CHK: begin
        if (cnt < rev) begin
          op         = DP_FETCH;
          state_next = S_BR_WA;
        end else if (cnt == n_mask) begin
          if (lg == '0) begin
            transform_done_next = 1'b1;
            state_next          = S_IDLE;
          end else begin
            stage_next = LOG2_W'(1);
            cnt_next   = '0;
            state_next = S_BF_RD;
          end
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_BR_WA: begin
        op         = DP_SWAP_A;
        state_next = S_BR_WB;
      end
      S_BR_WB: begin
        op = DP_SWAP_B;
        if (cnt == n_mask) begin
          if (lg == '0) begin
            transform_done_next = 1'b1;
            state_next          = S_IDLE;
          end else begin
            stage_next = LOG2_W'(1);
            cnt_next   = '0;
            state_next = S_BF_RD;
          end
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_BR_CHK;
        end
      end
      S_BF_RD: begin
        op         = DP_FETCH;
        state_next = S_BF_M0;
      end
      S_BF_M0: begin
        op         = DP_MUL0;
        state_next = S_BF_M1;
      end
      S_BF_M1: begin
        op         = DP_MUL1;
        state_next = S_BF_M2;
      end
      S_BF_M2: begin
        op         = DP_MUL2;
        state_next = S_BF_M3;
      end
      S_BF_M3: begin
        op         = DP_MUL3;
        state_next = S_BF_ADD;
      end
      S_BF_ADD: begin
        op         = DP_ACC;
        state_next = S_BF_WA;
      end
      S_BF_WA: begin
        op         = DP_WR_SUM;
        state_next = S_BF_WB;
      end
      S_BF_WB: begin
        op = DP_WR_DIF;
        if (cnt == last_t) begin
          cnt_next = '0;
          if (stage == lg) begin
            if (inverse) begin
              state_next = S_SC_RD;
            end else begin
              transform_done_next = 1'b1;
              state_next          = S_IDLE;
            end
          end else begin
            stage_next = stage + LOG2_W'(1);
            state_next = S_BF_RD;
          end
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_BF_RD;
        end
      end
      S_SC_RD: begin
        op         = DP_FETCH;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        op = DP_SCALE;
        if (cnt == n_mask) begin
          transform_done_next = 1'b1;
          state_next          = S_IDLE;
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_SC_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_LOG2: begin
          lg_next = (cfg_data > CFG_DATA_W'(MAX_LOG2_SIZE)) ?
                    LOG2_W'(MAX_LOG2_SIZE) : LOG2_W'(cfg_data);
          load_count_next     = '0;
          transform_done_next = 1'b0;
        end
        REG_INVERSE_MODE: begin
          inverse_next = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd = '{op: op, inverse: inverse, lg: lg, done: transform_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      lg             <= LG_RESET;
      inverse        <= 1'b0;
      load_count     <= '0;
      transform_done <= 1'b0;
      cnt            <= '0;
      stage          <= '0;
    end else begin
      state          <= state_next;
      lg             <= lg_next;
      inverse        <= inverse_next;
      load_count     <= load_count_next;
      transform_done <= transform_done_next;
      cnt            <= cnt_next;
      stage          <= stage_next;
    end
  end

endmodule

// ----- hw/rtl/r2fft_dp.sv -----
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample store, twiddle ROM, shared complex multiplier and butterfly adders.
// ----------------------------------------------------------------------------
module r2fft_dp
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int INPUT_WIDTH   = INPUT_WIDTH_DEF,
  parameter int WORD_WIDTH    = WORD_WIDTH_DEF,
  localparam int AW = MAX_LOG2_SIZE,
  localparam int TW_AW = (MAX_LOG2_SIZE > 1) ? MAX_LOG2_SIZE - 1 : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic [AW-1:0]                addr_a,
  input  logic [AW-1:0]                addr_b,
  input  logic [TW_AW-1:0]             tw_addr,
  input  logic signed [INPUT_WIDTH-1:0] sample_re,
  input  logic signed [INPUT_WIDTH-1:0] sample_im,
  output logic                         bin_valid,
  output logic signed [WORD_WIDTH-1:0] bin_re,
  output logic signed [WORD_WIDTH-1:0] bin_im,
  output logic                         bin_ready
);

  localparam int W   = WORD_WIDTH;
  localparam int PW  = W + TW_W;
  localparam int ACW = PW + 2;
  localparam int VW  = ACW - TW_FRAC;
  localparam int SW  = VW + 1;
  localparam int XW  = ((INPUT_WIDTH > W) ? INPUT_WIDTH : W) + 1;
  localparam int SCW = W + 1;

  localparam logic signed [SW-1:0]  S_HI = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0]  S_LO = ~S_HI;
  localparam logic signed [XW-1:0]  X_HI = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0]  X_LO = ~X_HI;
  localparam logic signed [ACW-1:0] RND  = ACW'(1) << (TW_FRAC - 1);

  function automatic logic signed [W-1:0] sat_sum(input logic signed [SW-1:0] x);
    logic signed [W-1:0] r;
    if (x > S_HI) begin
      r = S_HI[W-1:0];
    end else if (x < S_LO) begin
      r = S_LO[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_in(input logic signed [XW-1:0] x);
    logic signed [W-1:0] r;
    if (x > X_HI) begin
      r = X_HI[W-1:0];
    end else if (x < X_LO) begin
      r = X_LO[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  logic                   we;
  logic [AW-1:0]          waddr;
  logic [2*W-1:0]         wdata;
  logic [2*W-1:0]         rdata_a;
  logic [2*W-1:0]         rdata_b;
  logic signed [TW_W-1:0] cos_q;
  logic signed [TW_W-1:0] sin_q;

  logic signed [W-1:0]    u_re, u_im, b_re, b_im;
  logic signed [W-1:0]    mul_a;
  logic signed [TW_W-1:0] mul_w;
  logic signed [PW-1:0]   prod;
  logic signed [ACW-1:0]  acc_re, acc_im;
  logic signed [VW-1:0]   v_re, v_im;
  logic signed [W-1:0]    sum_re, sum_im, dif_re, dif_im;
  logic signed [SCW-1:0]  sc_rnd, sc_x_re, sc_x_im, sc_y_re, sc_y_im;

  r2fft_ram #(
    .WIDTH (2 * W),
    .DEPTH (1 << MAX_LOG2_SIZE)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    ((cmd.op == DP_READ) || (cmd.op == DP_FETCH)),
    .raddr_a (addr_a),
    .rdata_a (rdata_a),
    .re_b    (cmd.op == DP_FETCH),
    .raddr_b (addr_b),
    .rdata_b (rdata_b)
  );

  r2fft_twiddle #(
    .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
  ) u_twiddle (
    .clk   (clk),
    .rd_en (cmd.op == DP_FETCH),
    .addr  (tw_addr),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  assign u_re = $signed(rdata_a[2*W-1:W]);
  assign u_im = $signed(rdata_a[W-1:0]);
  assign b_re = $signed(rdata_b[2*W-1:W]);
  assign b_im = $signed(rdata_b[W-1:0]);

  assign mul_a = ((cmd.op == DP_MUL0) || (cmd.op == DP_MUL2)) ? b_re : b_im;
  assign mul_w = ((cmd.op == DP_MUL0) || (cmd.op == DP_MUL3)) ? cos_q : sin_q;

  // The twiddle's imaginary part is +sin in inverse mode and -sin otherwise,
  // so the sine products are added or subtracted instead of negating sin.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MUL0: begin
        prod <= mul_a * mul_w;
      end
      DP_MUL1: begin
        prod   <= mul_a * mul_w;
        acc_re <= ACW'(prod) + RND;
      end
      DP_MUL2: begin
        prod   <= mul_a * mul_w;
        acc_re <= cmd.inverse ? acc_re - ACW'(prod) : acc_re + ACW'(prod);
      end
      DP_MUL3: begin
        prod   <= mul_a * mul_w;
        acc_im <= cmd.inverse ? RND + ACW'(prod) : RND - ACW'(prod);
      end
      DP_ACC: begin
        acc_im <= acc_im + ACW'(prod);
      end
      default: begin
      end
    endcase
  end

  assign v_re = acc_re[ACW-1:TW_FRAC];
  assign v_im = acc_im[ACW-1:TW_FRAC];

  assign sum_re = sat_sum(SW'(u_re) + SW'(v_re));
  assign sum_im = sat_sum(SW'(u_im) + SW'(v_im));
  assign dif_re = sat_sum(SW'(u_re) - SW'(v_re));
  assign dif_im = sat_sum(SW'(u_im) - SW'(v_im));

  assign sc_rnd  = SCW'(1) << (cmd.lg - LOG2_W'(1));
  assign sc_x_re = SCW'(u_re) + sc_rnd;
  assign sc_x_im = SCW'(u_im) + sc_rnd;
  assign sc_y_re = sc_x_re >>> cmd.lg;
  assign sc_y_im = sc_x_im >>> cmd.lg;

  always_comb begin
    we    = 1'b1;
    waddr = addr_a;
    unique case (cmd.op)
      DP_LOAD:   wdata = {sat_in(XW'(sample_re)), sat_in(XW'(sample_im))};
      DP_WR_SUM: wdata = {sum_re, sum_im};
      DP_WR_DIF: begin
        wdata = {dif_re, dif_im};
        waddr = addr_b;
      end
      DP_SWAP_A: wdata = rdata_b;
      DP_SWAP_B: begin
        wdata = rdata_a;
        waddr = addr_b;
      end
      DP_SCALE:  wdata = {sc_y_re[W-1:0], sc_y_im[W-1:0]};
      default: begin
        we    = 1'b0;
        wdata = rdata_a;
      end
    endcase
  end

  assign bin_re = u_re;
  assign bin_im = u_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else begin
      bin_valid <= (cmd.op == DP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ) begin
      bin_ready <= cmd.done;
    end
  end

endmodule

// ----- hw/rtl/radix2_complex_fft.sv -----
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time complex FFT with load and read commands.
// ----------------------------------------------------------------------------
// A load is written in the cycle it is accepted; a read returns its bin on
// bin_valid in the cycle after it is accepted; loads and reads can be issued
// every cycle while not busy. The load completing a frame of n = 2^L points
// keeps busy high through the bit-reversal reordering, the n/2*L butterflies
// (bound by the single shared multiplier doing four products) and, for inverses,
// the scaling pass. Reset clears the control state and configuration; the
// sample store keeps whatever it held. The receiver cannot stall results.
module radix2_complex_fft
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int INPUT_WIDTH   = INPUT_WIDTH_DEF,
  parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic signed [INPUT_WIDTH-1:0] sample_re,
  input  logic signed [INPUT_WIDTH-1:0] sample_im,
  input  logic [BIN_INDEX_W-1:0]        bin_index,
  output logic                          bin_valid,
  output logic signed [WORD_WIDTH-1:0]  bin_re,
  output logic signed [WORD_WIDTH-1:0]  bin_im,
  output logic                          bin_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW    = MAX_LOG2_SIZE;
  localparam int TW_AW = (MAX_LOG2_SIZE > 1) ? MAX_LOG2_SIZE - 1 : 1;

  dp_cmd_t          cmd;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [TW_AW-1:0] tw_addr;

  r2fft_ctrl #(
    .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .bin_index (bin_index),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .tw_addr   (tw_addr)
  );

  r2fft_dp #(
    .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
    .INPUT_WIDTH   (INPUT_WIDTH),
    .WORD_WIDTH    (WORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .tw_addr   (tw_addr),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .bin_valid (bin_valid),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .bin_ready (bin_ready)
  );

  // A result strobe only ever follows an accepted read item.
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    bin_valid |-> $past(start && !busy && (command == CMD_READ)))
    else $error("result strobe without a read item");

  // A transform only begins right after a load item.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (command == CMD_LOAD)))
    else $error("transform started without a load item");

endmodule
